>>> src/smg_pkg.sv
// smg_pkg: shared types, codes and constants of the sphere mesh generator
// depends on nothing; imported by smg_ctrl, smg_datapath and the top level
`timescale 1ns / 1ps

package smg_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_DATA_W = 248;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EDGES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR    = 3'd5;

    // datapath operations, one multiply each except OP_NONE
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_SQ   = 4'd1;
    localparam logic [3:0] OP_HORN = 4'd2;
    localparam logic [3:0] OP_FIN  = 4'd3;
    localparam logic [3:0] OP_NX   = 4'd4;
    localparam logic [3:0] OP_NY   = 4'd5;
    localparam logic [3:0] OP_PX   = 4'd6;
    localparam logic [3:0] OP_PY   = 4'd7;
    localparam logic [3:0] OP_PZ   = 4'd8;

    // result record slots of one tick
    localparam logic [1:0] SLOT_VERT = 2'd0;
    localparam logic [1:0] SLOT_TRI0 = 2'd1;
    localparam logic [1:0] SLOT_TRI1 = 2'd2;

    // sine series coefficients, Q30
    localparam logic [31:0] C1 = 32'd1686629713;
    localparam logic [31:0] C3 = 32'd693598668;
    localparam logic [31:0] C5 = 32'd85569306;
    localparam logic [31:0] C7 = 32'd5026991;
    localparam logic [31:0] C9 = 32'd172272;

    typedef struct packed {
        logic       rewind;
        logic       div_step;
        logic [3:0] op;
        logic [1:0] sin_sel;
        logic [1:0] horn_idx;
        logic       rec_load;
        logic [1:0] rec_slot;
        logic       rec_last;
        logic       advance;
    } cmd_t;

    typedef struct packed {
        logic finished;
        logic add;
        logic has_tri;
        logic two_tri;
    } status_t;

    function automatic logic [31:0] horner_coef(input logic [1:0] idx);
        logic [31:0] c;
        case (idx)
            2'd0:    c = C7;
            2'd1:    c = C5;
            2'd2:    c = C3;
            default: c = C1;
        endcase
        return c;
    endfunction

endpackage

>>> src/smg_ctrl.sv
// smg_ctrl: sequencer of the sphere mesh generator
// depends on smg_pkg; drives smg_datapath through cmd_t, reads status_t
`timescale 1ns / 1ps

module smg_ctrl
    import smg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    input  logic    restart,
    output logic    m_axis_tvalid,
    input  logic    m_axis_tready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIVIDE = 3'd1;
    localparam logic [2:0] S_SIN    = 3'd2;
    localparam logic [2:0] S_NORM   = 3'd3;
    localparam logic [2:0] S_POS    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] sel_reg, sel_next;
    logic [1:0] slot_reg, slot_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_load;
    logic       last_c;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign can_load = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        case (slot_reg)
            SLOT_VERT: last_c = !status.has_tri;
            SLOT_TRI0: last_c = !status.two_tri;
            default:   last_c = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        slot_next = slot_reg;
        cmd = '0;
        cmd.op = OP_NONE;
        cmd.sin_sel = sel_reg;
        cmd.horn_idx = 2'(cnt_reg - 4'd1);
        cmd.rec_slot = slot_reg;
        cmd.rec_last = last_c;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (restart)
                    begin
                        cmd.rewind = 1'b1;
                        cnt_next = '0;
                        state_next = S_DIVIDE;
                    end
                    else if (!status.finished)
                    begin
                        cnt_next = '0;
                        sel_next = '0;
                        if (status.add)
                        begin
                            slot_next = SLOT_VERT;
                            state_next = S_SIN;
                        end
                        else
                        begin
                            slot_next = SLOT_TRI0;
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SIN:
            begin
                if (cnt_reg == 4'd0)
                    cmd.op = OP_SQ;
                else if (cnt_reg == 4'd5)
                    cmd.op = OP_FIN;
                else
                    cmd.op = OP_HORN;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd5)
                begin
                    cnt_next = '0;
                    sel_next = sel_reg + 2'd1;
                    if (sel_reg == 2'd3)
                        state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.op = (cnt_reg == 4'd0) ? OP_NX : OP_NY;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    cnt_next = '0;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                if (cnt_reg == 4'd0)
                    cmd.op = OP_PX;
                else if (cnt_reg == 4'd1)
                    cmd.op = OP_PY;
                else
                    cmd.op = OP_PZ;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd2)
                begin
                    cnt_next = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    cmd.rec_load = 1'b1;
                    if (last_c)
                    begin
                        cmd.advance = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.rec_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            sel_reg <= '0;
            slot_reg <= SLOT_VERT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
            slot_reg <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/smg_datapath.sv
// smg_datapath: grid counters, shared multiplier, sine series, step divider, records
// depends on smg_pkg; sequenced by smg_ctrl
`timescale 1ns / 1ps

module smg_datapath
    import smg_pkg::*;
#(
    parameter int MAX_EDGES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam logic [7:0] MAX_N = 8'(MAX_EDGES);

    // configuration
    logic [6:0]         edges_cfg_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [63:0]        color_reg;

    // grid state
    logic [6:0]  n_reg;
    logic [15:0] step_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  layer_reg;
    logic [7:0]  around_reg;
    logic [12:0] vert_reg;
    logic        fin_reg;
    logic [15:0] th_reg, ph_reg;

    // arithmetic
    logic [15:0]        t_reg, t2_reg;
    logic [31:0]        p_reg;
    logic               neg_reg;
    logic signed [15:0] sin_reg [4];
    logic signed [15:0] nx_reg, ny_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;

    // output record
    logic [OUT_DATA_W-1:0] data_reg;
    logic                  kind_reg;
    logic                  last_reg;

    logic [6:0]  n_clamp;
    logic [7:0]  div_r;
    logic        div_ge;
    logic [7:0]  d;
    logic [12:0] d13;
    logic        l0, l1, ln, add;
    logic [12:0] last_v, over, back, overback;
    logic [12:0] ta0, tb0, tc0;
    logic [7:0]  around_inc;

    logic [15:0]        phase;
    logic [14:0]        a15;
    logic [15:0]        t_comb;
    logic signed [16:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [48:0] prod;
    logic signed [48:0] prod_r14;
    logic [48:0]        prod_r29;
    logic [15:0]        s_mag;
    logic signed [31:0] center_sel;
    logic signed [31:0] pos_val;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    assign n_clamp = ({1'b0, edges_cfg_reg} < 8'd2) ? 7'd2 :
                     ({1'b0, edges_cfg_reg} > MAX_N) ? MAX_N[6:0] : edges_cfg_reg;

    // restoring divider, one quotient bit a cycle, quotient shifts into step_reg
    assign div_r  = {rem_reg, step_reg[15]};
    assign div_ge = (div_r >= {1'b0, n_reg});

    // grid decode
    assign d   = {n_reg, 1'b0};
    assign d13 = {5'd0, d};
    assign l0  = (layer_reg == 7'd0);
    assign l1  = (layer_reg == 7'd1);
    assign ln  = (layer_reg == n_reg);
    assign add = !(ln && (around_reg != 8'd0));

    assign status.finished = fin_reg;
    assign status.add      = add;
    assign status.has_tri  = !l0;
    assign status.two_tri  = !l0 && !l1 && !ln;

    assign last_v   = add ? vert_reg : vert_reg - 13'd1;
    assign over     = add ? last_v - d13 : last_v - d13 + {5'd0, around_reg};
    assign back     = (around_reg != 8'd0) ? last_v - 13'd1 : last_v + d13 - 13'd1;
    assign overback = (around_reg != 8'd0) ? over - 13'd1 : over + d13 - 13'd1;

    always_comb
    begin
        if (l1)
        begin
            ta0 = back;
            tb0 = last_v;
            tc0 = 13'd0;
        end
        else if (ln)
        begin
            ta0 = overback;
            tb0 = last_v;
            tc0 = over;
        end
        else
        begin
            ta0 = back;
            tb0 = last_v;
            tc0 = over;
        end
    end

    assign around_inc = around_reg + 8'd1;

    // quarter-wave folding of the selected phase, cosine is sine shifted a quarter
    assign phase  = (cmd.sin_sel[1] ? ph_reg : th_reg) + (cmd.sin_sel[0] ? 16'h4000 : 16'h0000);
    assign a15    = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    assign t_comb = {a15, 1'b0};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        center_sel = cx_reg;
        unique case (cmd.op)
            OP_SQ:
            begin
                mul_a = {1'b0, t_comb};
                mul_b = {16'd0, t_comb};
            end
            OP_HORN:
            begin
                mul_a = {1'b0, t2_reg};
                mul_b = p_reg;
            end
            OP_FIN:
            begin
                mul_a = {1'b0, t_reg};
                mul_b = p_reg;
            end
            OP_NX:
            begin
                mul_a = 17'(sin_reg[0]);
                mul_b = 32'(sin_reg[3]);
            end
            OP_NY:
            begin
                mul_a = 17'(sin_reg[0]);
                mul_b = 32'(sin_reg[2]);
            end
            OP_PX:
            begin
                mul_a = 17'(nx_reg);
                mul_b = {1'b0, radius_reg};
                center_sel = cx_reg;
            end
            OP_PY:
            begin
                mul_a = 17'(ny_reg);
                mul_b = {1'b0, radius_reg};
                center_sel = cy_reg;
            end
            OP_PZ:
            begin
                mul_a = 17'(sin_reg[1]);
                mul_b = {1'b0, radius_reg};
                center_sel = cz_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_r14 = prod + 49'sd16384;
    assign prod_r29 = prod + 49'sd536870912;
    assign s_mag    = (prod_r29[48:30] > 19'd32767) ? 16'd32767 : {1'b0, prod_r29[44:30]};
    assign pos_val  = sat32(35'($signed(prod_r14[48:15])) + 35'(center_sel));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_cfg_reg <= 7'd8;
            radius_reg <= 31'd65536;
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            color_reg <= '0;
            n_reg <= 7'd8;
            step_reg <= 16'd4096;
            rem_reg <= '0;
            layer_reg <= '0;
            around_reg <= '0;
            vert_reg <= '0;
            fin_reg <= 1'b0;
            th_reg <= '0;
            ph_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_EDGES:    edges_cfg_reg <= cfg_wdata[6:0];
                    REG_RADIUS:   radius_reg <= cfg_wdata[30:0];
                    REG_CENTER_X: cx_reg <= cfg_wdata[31:0];
                    REG_CENTER_Y: cy_reg <= cfg_wdata[31:0];
                    REG_CENTER_Z: cz_reg <= cfg_wdata[31:0];
                    REG_COLOR:    color_reg <= cfg_wdata;
                    default:      ;
                endcase
            end
            if (cmd.rewind)
            begin
                n_reg <= n_clamp;
                step_reg <= 16'h8000 + {10'd0, n_clamp[6:1]};
                rem_reg <= '0;
                layer_reg <= '0;
                around_reg <= '0;
                vert_reg <= '0;
                fin_reg <= 1'b0;
                th_reg <= '0;
                ph_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                rem_reg <= div_ge ? 7'(div_r - {1'b0, n_reg}) : div_r[6:0];
                step_reg <= {step_reg[14:0], div_ge};
            end
            else if (cmd.advance)
            begin
                if (add)
                    vert_reg <= vert_reg + 13'd1;
                if (l0)
                begin
                    layer_reg <= 7'd1;
                    around_reg <= '0;
                    th_reg <= step_reg;
                    ph_reg <= '0;
                end
                else if (around_inc >= d)
                begin
                    around_reg <= '0;
                    ph_reg <= '0;
                    if (layer_reg >= n_reg)
                        fin_reg <= 1'b1;
                    else
                    begin
                        layer_reg <= layer_reg + 7'd1;
                        th_reg <= th_reg + step_reg;
                    end
                end
                else
                begin
                    around_reg <= around_inc;
                    ph_reg <= ph_reg + step_reg;
                end
            end
        end
    end

    // arithmetic registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SQ:
            begin
                t_reg <= t_comb;
                t2_reg <= prod_r14[30:15];
                p_reg <= C9;
                neg_reg <= phase[15];
            end
            OP_HORN:
            begin
                p_reg <= horner_coef(cmd.horn_idx) - prod[46:15];
            end
            OP_FIN:
            begin
                sin_reg[cmd.sin_sel] <= neg_reg ? -$signed(s_mag) : $signed(s_mag);
            end
            OP_NX: nx_reg <= prod_r14[30:15];
            OP_NY: ny_reg <= prod_r14[30:15];
            OP_PX: px_reg <= pos_val;
            OP_PY: py_reg <= pos_val;
            OP_PZ: pz_reg <= pos_val;
            default: ;
        endcase
        if (cmd.rec_load)
        begin
            last_reg <= cmd.rec_last;
            if (cmd.rec_slot == SLOT_VERT)
            begin
                kind_reg <= 1'b0;
                data_reg <= {40'd0, color_reg, sin_reg[1], ny_reg, nx_reg,
                             pz_reg, py_reg, px_reg};
            end
            else if (cmd.rec_slot == SLOT_TRI0)
            begin
                kind_reg <= 1'b1;
                data_reg <= {1'b0, tc0, tb0, ta0, 208'd0};
            end
            else
            begin
                kind_reg <= 1'b1;
                data_reg <= {1'b0, overback, over, back, 208'd0};
            end
        end
    end

    assign m_axis_tdata = data_reg;
    assign m_axis_tuser = kind_reg;
    assign m_axis_tlast = last_reg;

endmodule

>>> src/sphere_mesh_generator.sv
// sphere_mesh_generator: top level of the streaming uv sphere tessellator
// depends on smg_pkg, smg_ctrl and smg_datapath
`timescale 1ns / 1ps

// Streaming latitude-longitude sphere mesh generator. Each request with
// restart clear visits one grid point and returns a vertex record (when the
// point adds a vertex) followed by up to two triangle records; tlast marks
// the final record of the request. A restart request returns nothing, latches
// the edge count and computes the phase step in a bit-serial divider; the
// block takes no request meanwhile. A point that adds a vertex is accepted,
// then runs the sine series (four sines, six steps each through the one
// shared 17x32 multiplier), the normal products and the scaled positions,
// and then emits its records. Points that add no vertex go straight to
// their triangle records. Requests after the south pole return nothing until
// restart. Results wait in an output register.
module sphere_mesh_generator
    import smg_pkg::*;
#(
    parameter int MAX_EDGES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // restart, zero pad
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, vertex_color,
    // corner_a, corner_b, corner_c, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [0:0]            m_axis_tuser,  // kind
    output logic                  m_axis_tlast
);

    cmd_t    cmd;     // sequencer commands
    status_t status;  // grid state seen by the sequencer

    smg_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .restart       (s_axis_tdata[0]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    smg_datapath #(
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .status       (status),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // a record never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rec_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("record overwrites pending result");

    // grid advances only with the final record of a request
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> (cmd.rec_load && cmd.rec_last))
        else $error("advance without final record");

    // no arithmetic or record while a request may enter
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (cmd.op == OP_NONE && !cmd.rec_load && !cmd.div_step))
        else $error("busy work while ready");
`endif

endmodule

>>> tb/sphere_mesh_generator_test.sv
// sphere_mesh_generator_test: self-checking stream testbench of the uv sphere generator
// depends on smg_pkg and the sphere_mesh_generator rtl
`timescale 1ns / 1ps

module sphere_mesh_generator_test;
    import smg_pkg::*;

    // series coefficients of the sine approximation, Q30
    localparam longint unsigned K1 = 64'd1686629713;
    localparam longint unsigned K3 = 64'd693598668;
    localparam longint unsigned K5 = 64'd85569306;
    localparam longint unsigned K7 = 64'd5026991;
    localparam longint unsigned K9 = 64'd172272;
    localparam int EDGE_CAP = 64;
    localparam int SETTLE = 80;
    localparam int NFLD = 12;

    typedef enum logic { REC_VERTEX = 1'b0, REC_TRIANGLE = 1'b1 } rec_kind_e;

    typedef struct {
        rec_kind_e   kind;
        logic [31:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic [63:0] col;
        logic [12:0] ca, cb, cc;
        logic        last;
    } mesh_rec_t;

    typedef logic [63:0] field_vec_t [NFLD];

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    sphere_mesh_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // mirrored configuration
    logic [6:0]         edges_reg = 7'd8;
    logic [30:0]        radius_reg = 31'd65536;
    logic signed [31:0] cx_reg = '0, cy_reg = '0, cz_reg = '0;
    logic [63:0]        color_reg = '0;

    // mirrored walk state; reset latches n=8, step 4096
    int unsigned layer_cnt = 0, around_cnt = 0, vert_cnt = 0;
    bit          past_south = 1'b0;
    int unsigned edges_act = 8, phase_inc = 4096;

    logic      pending_restart [$];   // requests waiting for the driver
    mesh_rec_t mesh_expected [$];     // records the block still owes

    bit      calm = 1'b0;             // stretch without idling on either side
    int      errors = 0;
    int      requests_sent = 0, vertices_seen = 0, triangles_seen = 0, spheres_done = 0;
    string   fld_name [NFLD] = '{"kind", "pos_x", "pos_y", "pos_z", "normal_x", "normal_y",
                                 "normal_z", "vertex_color", "corner_a", "corner_b",
                                 "corner_c", "last"};

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // prediction of the block
    // ---------------------------------------------------------------

    // sine over a quarter wave, a in [0,16384], result Q1.15
    function automatic longint quarter_wave(logic [16:0] a);
        longint unsigned t, t2, p, s;
        t  = 64'(a) << 1;
        t2 = (t * t + 64'd16384) >> 15;
        p  = K9;
        p  = K7 - ((t2 * p) >> 15);
        p  = K5 - ((t2 * p) >> 15);
        p  = K3 - ((t2 * p) >> 15);
        p  = K1 - ((t2 * p) >> 15);
        s  = (t * p + (64'd1 << 29)) >> 30;
        if (s > 64'd32767)
            s = 64'd32767;
        return longint'(s);
    endfunction

    function automatic longint phase_sine(logic [15:0] ph);
        logic [16:0] a;
        longint      s;
        a = {3'b000, ph[13:0]};
        if (ph[14])
            a = 17'd16384 - a;
        s = quarter_wave(a);
        return ph[15] ? -s : s;
    endfunction

    // floor((x + 2^14) / 2^15)
    function automatic longint q15_round(longint x);
        return (x + 64'sd16384) >>> 15;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic mesh_rec_t triangle(int unsigned a, int unsigned b, int unsigned c);
        mesh_rec_t r;
        r = '{kind: REC_TRIANGLE, default: '0};
        r.ca = a[12:0];
        r.cb = b[12:0];
        r.cc = c[12:0];
        return r;
    endfunction

    function automatic void rewind_walk();
        int unsigned n;
        n = edges_reg;
        if (n < 2)
            n = 2;
        if (n > EDGE_CAP)
            n = EDGE_CAP;
        edges_act  = n;
        phase_inc  = ((32768 + n / 2) / n) & 16'hffff;
        layer_cnt  = 0;
        around_cnt = 0;
        vert_cnt   = 0;
        past_south = 1'b0;
    endfunction

    // one accepted request: rewind on restart, else advance the grid walk and queue the records it yields
    function automatic void walk_grid_point(logic restart);
        int unsigned n, d, lay, phi, v, last_v, over, back, overback;
        bit          add;
        logic [15:0] th, ph;
        longint      st, ct, sp, cp, nx, ny, nz;
        mesh_rec_t   recs [$];
        mesh_rec_t   r;
        if (restart)
        begin
            rewind_walk();
            return;
        end
        if (past_south)
            return;
        n   = edges_act;
        d   = 2 * n;
        lay = layer_cnt;
        phi = around_cnt;
        v   = vert_cnt;
        add = !(lay == n && phi != 0);
        if (add)
        begin
            th = 16'(lay * phase_inc);
            ph = 16'(phi * phase_inc);
            st = phase_sine(th);
            ct = phase_sine(th + 16'd16384);
            sp = phase_sine(ph);
            cp = phase_sine(ph + 16'd16384);
            nx = q15_round(st * cp);
            ny = q15_round(st * sp);
            nz = ct;
            r = '{kind: REC_VERTEX, default: '0};
            r.px  = clamp32(longint'(cx_reg) + q15_round(nx * longint'(radius_reg)));
            r.py  = clamp32(longint'(cy_reg) + q15_round(ny * longint'(radius_reg)));
            r.pz  = clamp32(longint'(cz_reg) + q15_round(nz * longint'(radius_reg)));
            r.nx  = nx[15:0];
            r.ny  = ny[15:0];
            r.nz  = nz[15:0];
            r.col = color_reg;
            recs.push_back(r);
        end
        last_v   = add ? v : v - 1;
        over     = add ? last_v - d : last_v - d + phi;
        back     = (phi != 0) ? last_v - 1 : last_v + d - 1;
        overback = (phi != 0) ? over - 1 : over + d - 1;
        if (lay == 1)
            recs.push_back(triangle(back, last_v, 0));
        else if (lay == n)
            recs.push_back(triangle(overback, last_v, over));
        else if (lay != 0)
        begin
            recs.push_back(triangle(back, last_v, over));
            recs.push_back(triangle(back, over, overback));
        end
        recs[recs.size() - 1].last = 1'b1;
        foreach (recs[i])
            mesh_expected.push_back(recs[i]);

        if (add)
            vert_cnt = (v + 1) & 13'h1fff;
        if (lay == 0)
        begin
            layer_cnt  = 1;
            around_cnt = 0;
        end
        else
        begin
            around_cnt = phi + 1;
            if (around_cnt >= d)
            begin
                around_cnt = 0;
                if (lay >= n)
                begin
                    past_south = 1'b1;
                    spheres_done++;
                end
                else
                    layer_cnt = lay + 1;
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // request driver: pops the pending queue, idles at random
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                walk_grid_point(s_axis_tdata[0]);
                requests_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_restart.size() != 0 && (calm || $urandom_range(0, 99) >= 19))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, pending_restart.pop_front()};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor: random backpressure, field-by-field check
    // ---------------------------------------------------------------
    function automatic field_vec_t to_fields(mesh_rec_t r);
        field_vec_t f;
        f = '{64'(r.kind), 64'(r.px), 64'(r.py), 64'(r.pz), 64'(r.nx), 64'(r.ny),
              64'(r.nz), r.col, 64'(r.ca), 64'(r.cb), 64'(r.cc), 64'(r.last)};
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mesh_rec_t  got, want;
        field_vec_t fg, fw;
        bit         bad;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 19);
            if (m_axis_tvalid && m_axis_tready)
            begin
                // tdata layout from bit 0: pos xyz, normal xyz, color, corners abc
                got.kind = rec_kind_e'(m_axis_tuser[0]);
                got.px   = m_axis_tdata[31:0];
                got.py   = m_axis_tdata[63:32];
                got.pz   = m_axis_tdata[95:64];
                got.nx   = m_axis_tdata[111:96];
                got.ny   = m_axis_tdata[127:112];
                got.nz   = m_axis_tdata[143:128];
                got.col  = m_axis_tdata[207:144];
                got.ca   = m_axis_tdata[220:208];
                got.cb   = m_axis_tdata[233:221];
                got.cc   = m_axis_tdata[246:234];
                got.last = m_axis_tlast;
                if (got.kind == REC_VERTEX)
                    vertices_seen++;
                else
                    triangles_seen++;
                if (mesh_expected.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected record, kind %0d", $realtime, got.kind);
                end
                else
                begin
                    want = mesh_expected.pop_front();
                    fg   = to_fields(got);
                    fw   = to_fields(want);
                    bad  = 1'b0;
                    for (int i = 0; i < NFLD; i++)
                    begin
                        if (fg[i] !== fw[i])
                        begin
                            if (!bad)
                                errors++;
                            bad = 1'b1;
                            if (errors <= 10)
                                $display("[%0t] %s mismatch: expected %h got %h",
                                         $realtime, fld_name[i], fw[i], fg[i]);
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // waits until every request went in and every record came out, then lets
    // the block finish any restart or empty request still in flight
    task automatic wait_quiet();
        while (pending_restart.size() != 0 || s_axis_tvalid || mesh_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_EDGES:    edges_reg  = val[6:0];
            REG_RADIUS:   radius_reg = val[30:0];
            REG_CENTER_X: cx_reg     = val[31:0];
            REG_CENTER_Y: cy_reg     = val[31:0];
            REG_CENTER_Z: cz_reg     = val[31:0];
            REG_COLOR:    color_reg  = val;
            default: ;
        endcase
    endtask

    task automatic reg_done();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_center();
        case ($urandom_range(0, 5))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // ticks for a whole sphere at edge count n, plus up to three past the south pole
    function automatic int sphere_ticks(int unsigned raw);
        int unsigned n;
        n = (raw < 2) ? 2 : (raw > EDGE_CAP ? EDGE_CAP : raw);
        return 1 + 2 * n * n + $urandom_range(0, 3);
    endfunction

    task automatic queue_ticks(int cnt);
        for (int i = 0; i < cnt; i++)
            pending_restart.push_back(1'b0);
    endtask

    initial
    begin
        int queued, ticks;
        logic [6:0] n_pick;
        queued = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // walk from reset without restart: pole, first ring and start of the second at n=8
        queue_ticks(20);
        queued += 20;
        wait_quiet();

        // edge count below the minimum, largest radius, centers at the
        // extremes so positions saturate; restart mid-sphere and ticks
        // after the south pole
        reg_write(REG_EDGES, 64'd0);
        reg_write(REG_RADIUS, 64'h7fff_ffff);
        reg_write(REG_CENTER_X, 64'h7fff_ffff);
        reg_write(REG_CENTER_Y, 64'hffff_ffff_8000_0000);
        reg_write(REG_CENTER_Z, 64'h0);
        reg_write(REG_COLOR, 64'hffff_ffff_ffff_ffff);
        reg_write(3'd6, 64'hdead_beef);
        reg_write(3'd7, 64'h1234_5678);
        reg_done();
        pending_restart.push_back(1'b1);
        queue_ticks(5);
        pending_restart.push_back(1'b1);
        queue_ticks(12);
        queued += 19;
        wait_quiet();

        // edge count above the cap, zero radius, centers at the extremes;
        // back to back with no idling on either side
        calm = 1'b1;
        reg_write(REG_EDGES, 64'd127);
        reg_write(REG_RADIUS, 64'd0);
        reg_write(REG_CENTER_X, 64'h8000_0000);
        reg_write(REG_CENTER_Z, 64'h7fff_ffff);
        reg_write(REG_COLOR, 64'h0);
        reg_done();
        pending_restart.push_back(1'b1);
        queue_ticks(140);
        queued += 141;
        wait_quiet();
        calm = 1'b0;

        // random phases: mostly complete spheres at small edge counts
        while (queued < 470)
        begin
            calm = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0:       n_pick = $urandom_range(0, 1);
                1:       n_pick = $urandom_range(65, 127);
                2:       n_pick = 7'd64;
                default: n_pick = $urandom_range(2, 6);
            endcase
            reg_write(REG_EDGES, {57'd0, n_pick});
            if ($urandom_range(0, 1))
                reg_write(REG_RADIUS, ($urandom_range(0, 3) == 0) ? 64'h7fff_ffff
                                                                   : {32'd0, $urandom});
            if ($urandom_range(0, 1))
                reg_write(REG_CENTER_X, {32'd0, pick_center()});
            if ($urandom_range(0, 1))
                reg_write(REG_CENTER_Y, {32'd0, pick_center()});
            if ($urandom_range(0, 1))
                reg_write(REG_CENTER_Z, {32'd0, pick_center()});
            reg_write(REG_COLOR, {$urandom, $urandom});
            reg_done();
            if ($urandom_range(0, 4) != 0)
            begin
                pending_restart.push_back(1'b1);
                queued++;
            end
            ticks = (n_pick >= 2 && n_pick <= 6) || n_pick < 2 ? sphere_ticks(n_pick)
                                                                : $urandom_range(30, 90);
            // keep the total close to the planned request count
            if (queued + ticks > 480)
                ticks = 480 - queued;
            for (int i = 0; i < ticks; i++)
                pending_restart.push_back($urandom_range(0, 39) == 0);
            queued += ticks;
            wait_quiet();
        end
        calm = 1'b0;

        $display("requests %0d, vertices %0d, triangles %0d, spheres completed %0d",
                 requests_sent, vertices_seen, triangles_seen, spheres_done);
        $display("covered clamped edge counts, saturating positions, restarts and ticks past the pole");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d records outstanding", mesh_expected.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sphere_mesh_generator.f
src/smg_pkg.sv
src/smg_ctrl.sv
src/smg_datapath.sv
src/sphere_mesh_generator.sv
tb/sphere_mesh_generator_test.sv
